// ===== rtl/mme_pkg.sv =====
package mme_pkg;

  // sizes fixed by the request and result formats
  localparam int unsigned PC_W       = 8;
  localparam int unsigned LEN_W      = PC_W + 1;
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned IMM_W      = 32;
  localparam int unsigned COUNT_W    = 20;
  localparam int unsigned NEXT_W     = IMM_W + 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = COUNT_W;

  // default sizing of the top level
  localparam int unsigned MAX_PROGRAM = 128;
  localparam int unsigned NUM_REGS    = 32;

  // fixed values of the instruction set
  localparam logic [DATA_W-1:0]     SYSCALL_EXIT_CODE = DATA_W'(10);
  localparam int unsigned           LUI_SHIFT         = 16;
  localparam logic [REG_ADDR_W-1:0] SYSCALL_REG       = REG_ADDR_W'(2);

  // register reset values
  localparam logic [PC_W-1:0]    PROGRAM_LENGTH_RESET = PC_W'(1);
  localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET     = COUNT_W'(1000000);
  localparam logic [PC_W-1:0]    PC_RESET             = PC_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT     = 1'b1;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_ORI     = 3'd2,
    CMD_LI      = 3'd3,
    CMD_LUI     = 3'd4,
    CMD_BEQ     = 3'd5,
    CMD_SYSCALL = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_FINISHED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_LIMIT    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                    command;
    logic [REG_ADDR_W-1:0]   dest_reg;
    logic [REG_ADDR_W-1:0]   src_reg;
    logic [REG_ADDR_W-1:0]   src2_reg;
    logic signed [IMM_W-1:0] immediate;
  } in_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     wrote;
    logic [REG_ADDR_W-1:0]    write_reg;
    logic signed [DATA_W-1:0] write_value;
    logic [1:0]               status;
  } out_t;

endpackage

// ===== rtl/mme_regfile.sv =====
module mme_regfile import mme_pkg::*; #(
  parameter int unsigned NumRegs = NUM_REGS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [REG_ADDR_W-1:0] rd_addr_a_i,
  input  logic [REG_ADDR_W-1:0] rd_addr_b_i,
  input  logic                  wr_en_i,
  input  logic [REG_ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]     wr_data_i,
  output logic [DATA_W-1:0]     rd_data_a_o,
  output logic [DATA_W-1:0]     rd_data_b_o
);

  localparam int unsigned IdxW = $clog2(NumRegs);

  logic [DATA_W-1:0]  mem [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [DATA_W-1:0]  raw_a_q, raw_b_q, fwd_data_q;
  logic               ok_a_q, ok_b_q, fwd_a_q, fwd_b_q;
  logic [IdxW-1:0]    idx_a, idx_b, idx_w;
  logic               rng_a, rng_b;

  // index decode, anything past the last register reads as zero
  assign idx_a = rd_addr_a_i[IdxW-1:0];
  assign idx_b = rd_addr_b_i[IdxW-1:0];
  assign idx_w = wr_addr_i[IdxW-1:0];
  assign rng_a = {1'b0, rd_addr_a_i} < (REG_ADDR_W + 1)'(NumRegs);
  assign rng_b = {1'b0, rd_addr_b_i} < (REG_ADDR_W + 1)'(NumRegs);

  // storage array with registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[idx_w] <= wr_data_i;
    end
    if (rd_en_i) begin
      raw_a_q    <= mem[idx_a];
      raw_b_q    <= mem[idx_b];
      fwd_data_q <= wr_data_i;
    end
  end

  // written flags, an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[idx_w] <= 1'b1;
    end
  end

  // read qualifiers and bypass of a write landing on the read edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_a_q  <= 1'b0;
      ok_b_q  <= 1'b0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else if (rd_en_i) begin
      ok_a_q  <= rng_a && vld_q[idx_a];
      ok_b_q  <= rng_b && vld_q[idx_b];
      fwd_a_q <= wr_en_i && (wr_addr_i == rd_addr_a_i);
      fwd_b_q <= wr_en_i && (wr_addr_i == rd_addr_b_i);
    end
  end

  assign rd_data_a_o = fwd_a_q ? fwd_data_q : (ok_a_q ? raw_a_q : '0);
  assign rd_data_b_o = fwd_b_q ? fwd_data_q : (ok_b_q ? raw_b_q : '0);

endmodule

// ===== rtl/mini_mips_executor_unit.sv =====
// pipeline: a request is registered into the execute stage with its register file
// read, and its result into the output register, which holds it until taken
// throughput: one request per cycle while the output is not stalled, set by the
// register file read in the accept cycle and its write-back in the execute cycle
// reset: register file reads as zero, pc 1, count 0, status running,
// program length 1 and step limit 1000000, all at once with no clearing pass
module mini_mips_executor_unit import mme_pkg::*; #(
  parameter int unsigned MaxProgram = MAX_PROGRAM,
  parameter int unsigned NumRegs    = NUM_REGS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_res_o
);

  logic [PC_W-1:0]    prog_len_q;
  logic [COUNT_W-1:0] step_limit_q;
  logic [PC_W-1:0]    pc_q;
  logic [COUNT_W-1:0] count_q, count_d;
  status_e            halt_q;

  logic    s2_vld_q, s2_adv, in_acc;
  in_t     s2_q;
  logic    out_vld_q;
  out_t    out_q, res;

  logic [REG_ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0]     opa, opb, imm_ext, value;
  logic                  wr_cmd, wr_ok, taken, sys_hit, halted, below, above;
  logic signed [NEXT_W-1:0] next_s, len_s;
  logic [LEN_W-1:0]      len_clamp;
  status_e               status;

  // handshake and pipeline advance
  assign s2_adv      = !out_vld_q || out_ready_i;
  assign in_ready_o  = !s2_vld_q || s2_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  // operand port selection per command
  always_comb begin
    rd_addr_a = in_req_i.src_reg;
    rd_addr_b = in_req_i.src2_reg;
    case (in_req_i.command)
      CMD_BEQ: begin
        rd_addr_a = in_req_i.dest_reg;
        rd_addr_b = in_req_i.src_reg;
      end
      CMD_SYSCALL: begin
        rd_addr_a = SYSCALL_REG;
      end
      default: ;
    endcase
  end

  mme_regfile #(
    .NumRegs(NumRegs)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .wr_en_i     (s2_vld_q && s2_adv && res.wrote),
    .wr_addr_i   (s2_q.dest_reg),
    .wr_data_i   (value),
    .rd_data_a_o (opa),
    .rd_data_b_o (opb)
  );

  // execute
  always_comb begin
    imm_ext = {{(DATA_W - IMM_W){s2_q.immediate[IMM_W-1]}}, s2_q.immediate};
    value   = '0;
    wr_cmd  = 1'b0;
    taken   = 1'b0;
    sys_hit = 1'b0;
    case (s2_q.command)
      CMD_ADD: begin
        value  = opa + opb;
        wr_cmd = 1'b1;
      end
      CMD_SUB: begin
        value  = opa - opb;
        wr_cmd = 1'b1;
      end
      CMD_ORI: begin
        value  = opa | imm_ext;
        wr_cmd = 1'b1;
      end
      CMD_LI: begin
        value  = imm_ext;
        wr_cmd = 1'b1;
      end
      CMD_LUI: begin
        value  = imm_ext << LUI_SHIFT;
        wr_cmd = 1'b1;
      end
      CMD_BEQ: begin
        taken = (opa == opb);
      end
      CMD_SYSCALL: begin
        sys_hit = (opa == SYSCALL_EXIT_CODE);
      end
      default: ;
    endcase
  end

  // next pc, range checks and step count
  always_comb begin
    halted    = (halt_q != ST_RUNNING);
    wr_ok     = wr_cmd && (s2_q.dest_reg != '0)
                && ({1'b0, s2_q.dest_reg} < (REG_ADDR_W + 1)'(NumRegs));
    next_s    = signed'(NEXT_W'({1'b0, pc_q})) + signed'(NEXT_W'(1));
    if (taken) begin
      next_s = next_s + signed'({{(NEXT_W - IMM_W){s2_q.immediate[IMM_W-1]}},
                                 s2_q.immediate});
    end
    len_clamp = ({1'b0, prog_len_q} > LEN_W'(MaxProgram)) ? LEN_W'(MaxProgram)
                                                          : {1'b0, prog_len_q};
    len_s     = signed'(NEXT_W'(len_clamp));
    below     = (next_s < signed'(NEXT_W'(1)));
    above     = (next_s > len_s);
    count_d   = count_q + COUNT_W'(1);
    if (sys_hit) begin
      status = ST_FINISHED;
    end else if (below || above) begin
      status = ST_DROPPED;
    end else if (count_d >= step_limit_q) begin
      status = ST_LIMIT;
    end else begin
      status = ST_RUNNING;
    end
  end

  // result assembly, a halted block reports only its sticky status
  always_comb begin
    res = '0;
    if (halted) begin
      res.status = halt_q;
    end else begin
      res.status = status;
      if (status == ST_RUNNING) begin
        res.next_pc = next_s[PC_W-1:0];
      end
      if (wr_ok) begin
        res.wrote       = 1'b1;
        res.write_reg   = s2_q.dest_reg;
        res.write_value = value;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q   <= PROGRAM_LENGTH_RESET;
      step_limit_q <= STEP_LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PROGRAM_LENGTH) begin
        prog_len_q <= cfg_data_i[PC_W-1:0];
      end else begin
        step_limit_q <= cfg_data_i;
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PC_RESET;
      count_q <= '0;
      halt_q  <= ST_RUNNING;
    end else if (s2_vld_q && s2_adv && !halted) begin
      count_q <= count_d;
      if (status == ST_RUNNING) begin
        pc_q <= next_s[PC_W-1:0];
      end else begin
        halt_q <= status;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s2_vld_q <= in_valid_i;
      end
      if (s2_adv) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_q <= in_req_i;
    end
    if (s2_vld_q && s2_adv) begin
      out_q <= res;
    end
  end

endmodule

// ===== dv/mini_mips_executor_unit_tb.sv =====
`timescale 1ns / 100ps

module mini_mips_executor_unit_tb;
  import mme_pkg::*;

  // clock, reset and block ports
  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_req_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_res_o;

  // architectural state tracked alongside the block
  logic [DATA_W-1:0]  arch_regs [NUM_REGS];
  logic [PC_W-1:0]    arch_pc;
  logic [COUNT_W-1:0] retired_count;
  status_e            halt_state;
  logic [PC_W-1:0]    prog_length;
  logic [COUNT_W-1:0] step_budget;

  // results still owed by the block, oldest first
  out_t pending_results [$];

  int    tx_idle_pct;
  int    rx_idle_pct;
  int    rx_hold_cycles;
  bit    tx_valid_up;
  int    issued;
  int    results_checked;
  int    mismatches;
  string halt_path;

  mini_mips_executor_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout: %0d requests issued, %0d results checked", issued, results_checked);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int effective_len();
    return (prog_length > MAX_PROGRAM) ? int'(MAX_PROGRAM) : int'(prog_length);
  endfunction

  // execute one instruction on the tracked state and give the result it owes
  function automatic out_t execute_instr(in_t req);
    out_t              res;
    logic [DATA_W-1:0] imm64;
    logic [DATA_W-1:0] val;
    logic              do_write;
    longint            nxt;
    status_e           st;
    res = '0;
    if (halt_state != ST_RUNNING) begin
      res.status = halt_state;
      return res;
    end
    imm64    = {{(DATA_W-IMM_W){req.immediate[IMM_W-1]}}, req.immediate};
    nxt      = longint'(arch_pc) + 1;
    do_write = 1'b0;
    val      = '0;
    st       = ST_RUNNING;
    case (req.command)
      CMD_ADD: begin
        val      = arch_regs[req.src_reg] + arch_regs[req.src2_reg];
        do_write = 1'b1;
      end
      CMD_SUB: begin
        val      = arch_regs[req.src_reg] - arch_regs[req.src2_reg];
        do_write = 1'b1;
      end
      CMD_ORI: begin
        val      = arch_regs[req.src_reg] | imm64;
        do_write = 1'b1;
      end
      CMD_LI: begin
        val      = imm64;
        do_write = 1'b1;
      end
      CMD_LUI: begin
        val      = imm64 << LUI_SHIFT;
        do_write = 1'b1;
      end
      CMD_BEQ: begin
        if (arch_regs[req.dest_reg] == arch_regs[req.src_reg]) nxt = nxt + $signed(imm64);
      end
      CMD_SYSCALL: begin
        if (arch_regs[SYSCALL_REG] == SYSCALL_EXIT_CODE) st = ST_FINISHED;
      end
      default: ;
    endcase
    // register zero never changes
    if (do_write && req.dest_reg != '0) begin
      arch_regs[req.dest_reg] = val;
      res.wrote       = 1'b1;
      res.write_reg   = req.dest_reg;
      res.write_value = val;
    end
    retired_count = retired_count + 1'b1;
    // halt priority: syscall, then leaving the program, then the step budget
    if (st == ST_RUNNING && (nxt < 1 || nxt > effective_len())) st = ST_DROPPED;
    if (st == ST_RUNNING && retired_count >= step_budget) st = ST_LIMIT;
    if (st == ST_RUNNING) begin
      arch_pc     = nxt[PC_W-1:0];
      res.next_pc = arch_pc;
    end else begin
      halt_state = st;
    end
    res.status = st;
    return res;
  endfunction

  function automatic in_t instr(cmd_e cmd, logic [REG_ADDR_W-1:0] rd,
                                logic [REG_ADDR_W-1:0] rs, logic [REG_ADDR_W-1:0] rt,
                                logic [IMM_W-1:0] imm);
    in_t r;
    r.command   = cmd;
    r.dest_reg  = rd;
    r.src_reg   = rs;
    r.src2_reg  = rt;
    r.immediate = imm;
    return r;
  endfunction

  function automatic logic [IMM_W-1:0] pick_imm();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return IMM_W'($urandom_range(16));
      default: return IMM_W'($urandom());
    endcase
  endfunction

  // random instruction that keeps the program running, short of the step budget
  function automatic in_t pick_running_instr();
    in_t r;
    int  len;
    int  target;
    r = instr(cmd_e'($urandom_range(7)), REG_ADDR_W'($urandom_range(31)),
              REG_ADDR_W'($urandom_range(31)), REG_ADDR_W'($urandom_range(31)), pick_imm());
    len = effective_len();
    if (r.command == CMD_SYSCALL && arch_regs[SYSCALL_REG] == SYSCALL_EXIT_CODE)
      r.command = CMD_NOP;
    // at or past the last instruction only a taken branch stays in range
    if (int'(arch_pc) >= len) r.command = CMD_BEQ;
    if (r.command == CMD_BEQ) begin
      if (int'(arch_pc) >= len || $urandom_range(3) != 0) r.src_reg = r.dest_reg;
      if (arch_regs[r.dest_reg] == arch_regs[r.src_reg]) begin
        target      = $urandom_range(len, 1);
        r.immediate = IMM_W'(target - int'(arch_pc) - 1);
      end
    end
    return r;
  endfunction

  // offer one request and wait for it to be taken
  task automatic issue_instr(input in_t req);
    if (!tx_valid_up) begin
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_req_i    <= req;
    tx_valid_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(execute_instr(req));
    issued++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i  <= 1'b0;
      tx_valid_up = 1'b0;
    end
  endtask

  task automatic issue_goto(input int target);
    issue_instr(instr(CMD_BEQ, '0, '0, '0, IMM_W'(target - int'(arch_pc) - 1)));
  endtask

  // sender pause until every owed result is back
  task automatic settle();
    if (tx_valid_up) begin
      in_valid_i  <= 1'b0;
      tx_valid_up = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CFG_PROGRAM_LENGTH) prog_length = data[PC_W-1:0];
    else step_budget = data[COUNT_W-1:0];
  endtask

  // negative value leaves that register alone
  task automatic program_config(input int len, input longint lim);
    settle();
    if (len >= 0) write_config(CFG_PROGRAM_LENGTH, CFG_DATA_W'(len));
    if (lim >= 0) write_config(CFG_STEP_LIMIT, CFG_DATA_W'(lim));
    cfg_we_i <= 1'b0;
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("error: %s", msg);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result pc %0d status %0d", got.next_pc, got.status));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.next_pc !== want.next_pc)
      flag_mismatch($sformatf("result %0d next_pc %0d, want %0d",
                              results_checked, got.next_pc, want.next_pc));
    if (got.wrote !== want.wrote)
      flag_mismatch($sformatf("result %0d wrote %0b, want %0b",
                              results_checked, got.wrote, want.wrote));
    if (got.write_reg !== want.write_reg)
      flag_mismatch($sformatf("result %0d write_reg %0d, want %0d",
                              results_checked, got.write_reg, want.write_reg));
    if (got.write_value !== want.write_value)
      flag_mismatch($sformatf("result %0d write_value %h, want %h",
                              results_checked, got.write_value, want.write_value));
    if (got.status !== want.status)
      flag_mismatch($sformatf("result %0d status %0d, want %0d",
                              results_checked, got.status, want.status));
  endtask

  // result side: check each accepted result, then pick the next ready
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result(out_res_o);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // reset values: length 1 and pc 1, so only a branch back to 1 keeps running
  task automatic test_reset_state();
    issue_instr(instr(CMD_BEQ, '0, '0, '0, -1));
    issue_instr(instr(CMD_BEQ, 5'd3, 5'd4, '0, -1));
  endtask

  // wrap-around, sign extension, register zero, syscall compare, branch bounds
  task automatic test_directed_ops();
    issue_instr(instr(CMD_LI,  5'd1,  '0,    '0,   '1));
    issue_instr(instr(CMD_LI,  5'd3,  '0,    '0,   32'd1));
    issue_instr(instr(CMD_ADD, 5'd4,  5'd1,  5'd3, '0));
    issue_instr(instr(CMD_SUB, 5'd5,  '0,    5'd3, '0));
    issue_instr(instr(CMD_LUI, 5'd6,  '0,    '0,   32'h7fff_ffff));
    issue_instr(instr(CMD_LUI, 5'd7,  '0,    '0,   32'h8000_0000));
    issue_instr(instr(CMD_ORI, 5'd8,  5'd6,  '0,   32'h8000_0000));
    issue_instr(instr(CMD_LI,  5'd11, '0,    '0,   32'h7fff_ffff));
    issue_instr(instr(CMD_LI,  5'd12, '0,    '0,   32'h8000_0000));
    issue_instr(instr(CMD_LI,  '0,    '0,    '0,   32'h0001_2345));
    issue_instr(instr(CMD_ADD, 5'd9,  '0,    5'd1, '0));
    // register 2 with exit code in the low word only
    issue_instr(instr(CMD_LUI, 5'd10, '0,    '0,   32'h0001_0000));
    issue_instr(instr(CMD_ORI, SYSCALL_REG, 5'd10, '0, 32'd10));
    issue_instr(instr(CMD_SYSCALL, '0, '0,   '0,   '0));
    issue_instr(instr(CMD_NOP, 5'd31, 5'd31, 5'd31, '1));
    issue_instr(instr(CMD_BEQ, 5'd1,  5'd5,  '0,   '0));
    issue_instr(instr(CMD_BEQ, 5'd1,  5'd3,  '0,   32'h7fff_ffff));
    issue_goto(effective_len());
    issue_goto(1);
    issue_instr(instr(CMD_LI,  SYSCALL_REG, '0, '0, 32'd10));
    issue_instr(instr(CMD_SUB, 5'd31, 5'd1,  5'd12, '0));
    issue_instr(instr(CMD_LI,  SYSCALL_REG, '0, '0, 32'd3));
  endtask

  task automatic test_random_program(input int count);
    for (int i = 0; i < count; i++) issue_instr(pick_running_instr());
  endtask

  // long receiver stall while requests keep coming, then a full drain
  task automatic test_backpressure();
    rx_hold_cycles = 80;
    test_random_program(40);
    settle();
  endtask

  // one way of halting per run, chosen at random
  task automatic test_halt_path();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(4);
    case (pick)
      0: begin
        halt_path = "syscall exit at last pc with budget spent";
        issue_goto(1);
        issue_instr(instr(CMD_LI, SYSCALL_REG, '0, '0, 32'd10));
        issue_goto(effective_len());
        program_config(-1, longint'(retired_count) + 1);
        issue_instr(instr(CMD_SYSCALL, '0, '0, '0, '0));
      end
      1: begin
        halt_path = "running past the last pc with budget spent";
        issue_goto(effective_len());
        program_config(-1, longint'(retired_count) + 1);
        issue_instr(instr(CMD_NOP, '0, '0, '0, '0));
      end
      2: begin
        halt_path = "branch below the first pc";
        if ($urandom_range(1) == 0) issue_goto(0);
        else issue_instr(instr(CMD_BEQ, 5'd20, 5'd20, '0, 32'h8000_0000));
      end
      3: begin
        halt_path = "program length zero";
        program_config(0, -1);
        issue_instr(instr(CMD_LI, 5'd13, '0, '0, pick_imm()));
      end
      default: begin
        halt_path = "step budget";
        case ($urandom_range(2))
          0: begin
            k = $urandom_range(4, 1);
            program_config(-1, longint'(retired_count) + k);
            test_random_program(k);
          end
          1: begin
            program_config(-1, 0);
            test_random_program(1);
          end
          default: begin
            program_config(-1, 1);
            test_random_program(1);
          end
        endcase
      end
    endcase
  endtask

  // once halted every request is answered with the sticky status
  task automatic test_halted_block();
    for (int i = 0; i < 30; i++)
      issue_instr(instr(cmd_e'($urandom_range(7)), REG_ADDR_W'($urandom_range(31)),
                        REG_ADDR_W'($urandom_range(31)), REG_ADDR_W'($urandom_range(31)),
                        pick_imm()));
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
    arch_pc        = PC_RESET;
    retired_count  = '0;
    halt_state     = ST_RUNNING;
    prog_length    = PROGRAM_LENGTH_RESET;
    step_budget    = STEP_LIMIT_RESET;
    tx_idle_pct    = 16;
    rx_idle_pct    = 76;
    rx_hold_cycles = 0;
    tx_valid_up    = 1'b0;
    issued         = 0;
    results_checked = 0;
    mismatches     = 0;
    halt_path      = "none";

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles lightly, receiver heavily
    test_reset_state();
    program_config(128, (1 << COUNT_W) - 1);
    test_directed_ops();
    test_random_program(470);

    // the other way round, length above the program store
    program_config(255, 1000000);
    tx_idle_pct = 76;
    rx_idle_pct = 16;
    test_random_program(470);

    // no idling, short program
    program_config(37, 4000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_program(420);
    test_backpressure();

    test_halt_path();
    test_halted_block();

    settle();
    repeat (10) @(posedge clk_i);
    $display("covered: %0d requests, %0d results checked, program lengths 1/128/255/37",
             issued, results_checked);
    $display("covered: halt by %s, then requests against the halted block", halt_path);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
